// ----- hdl/tto_pkg.sv -----
package tto_pkg;

  // Component and fixed-point formats
  localparam int CB   = 16;        // bits per packed component
  localparam int NF   = CB - 4;    // normal fraction bits (Q4.12)
  localparam int OF   = CB - 2;    // output fraction bits (Q2.14)
  localparam int UTOP = 24;        // raw tangent scaled into [2^23, 2^24)
  localparam int WTOP = 30;        // projected tangent scaled into [2^29, 2^30)

  // Datapath widths
  localparam int EW   = CB + 1;            // edge and UV delta
  localparam int PW   = 2 * EW;            // edge products
  localparam int URW  = PW + 1;            // raw tangent, signed
  localparam int UMW  = PW;                // raw tangent magnitude
  localparam int USW  = UTOP + 2;          // scaled raw tangent, signed
  localparam int DPW  = CB + USW;          // normal times tangent
  localparam int DOTW = DPW + 2;           // dot product
  localparam int PPW  = DOTW - NF + 1;     // rounded projection length
  localparam int NPW  = CB + PPW;          // normal times projection
  localparam int RW   = NPW - NF + 1;      // rounded normal component
  localparam int WW   = RW + 1;            // projected tangent, signed
  localparam int WMW  = WW;                // projected tangent magnitude
  localparam int HW   = $clog2(WMW);       // leading-one position
  localparam int SCW  = WTOP + 1;          // scaled magnitude
  localparam int SQW  = 2 * SCW;           // square
  localparam int SUMW = SQW + 2;           // sum of squares
  localparam int SQ_STEPS = SUMW / 2;      // root digits
  localparam int LW   = SQ_STEPS;          // vector length
  localparam int REMW = LW + 4;            // root remainder
  localparam int QW   = CB;                // quotient digits
  localparam int NUMW = SCW + OF + 1;      // dividend

  // Pipeline depth, input register to output register
  localparam int NST = 16 + SQ_STEPS + 1 + QW + 1 + 1;

  // Status codes
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DET  = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  typedef struct packed {
    logic [3*CB-1:0] surface_normal;
    logic [2*CB-1:0] tex_c;
    logic [2*CB-1:0] tex_b;
    logic [2*CB-1:0] tex_a;
    logic [3*CB-1:0] pos_c;
    logic [3*CB-1:0] pos_b;
    logic [3*CB-1:0] pos_a;
  } tto_in_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [3*CB-1:0] unit_tangent;
  } tto_out_t;

endpackage

// ----- hdl/triangle_tangent_orthonormalize_core.sv -----
// Triangle tangent orthonormalizer.
// Input channel tri_*: one beat carries a triangle (three Q8.8 positions, three
// Q4.12 UVs and a Q4.12 normal). Output channel tan_*: one beat carries the
// unit tangent (Q2.14 x,y,z) and a status code: ok, zero UV determinant, or
// zero vector after removing the normal. On either error the tangent is zero.
// Throughput: one triangle per cycle while the output is not stalled. Between
// the accepting edge and the output register lie a digit-by-digit square
// root and a per-lane long division that normalizes the tangent.
// All stages advance together. When the receiver stalls a valid result, the
// whole pipeline holds and tri_stall rises in the same cycle; while the output
// register is empty or being taken, a triangle is accepted every cycle.
// Reset (rst, synchronous) clears only the stage valid bits; no item is in
// flight afterwards and no result appears until a triangle is accepted.
module triangle_tangent_orthonormalize_core
  import tto_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     tri_valid,
  output logic     tri_stall,
  input  tto_in_t  tri_data,
  output logic     tan_valid,
  input  logic     tan_stall,
  output tto_out_t tan_data
);

  function automatic logic signed [CB-1:0] comp3(input logic [3*CB-1:0] f, input int i);
    return f[i*CB +: CB];
  endfunction

  function automatic logic signed [CB-1:0] comp2(input logic [2*CB-1:0] f, input int i);
    return f[i*CB +: CB];
  endfunction

  // Position of the highest set bit; zero for a zero word.
  function automatic logic [HW-1:0] lead1(input logic [WMW-1:0] v);
    logic [HW-1:0] h;
    h = '0;
    for (int k = 0; k < WMW; k++) begin
      if (v[k]) h = HW'(k);
    end
    return h;
  endfunction

  // Shift a magnitude so that its top bit lands at top1; right shifts round
  // half away from zero.
  function automatic logic [SCW-1:0] scale_mag(input logic [WMW-1:0] m,
                                               input logic [HW-1:0] h,
                                               input logic [HW-1:0] top1);
    logic [WMW:0]  t;
    logic [HW-1:0] d;
    if (h > top1) begin
      d = h - top1;
      t = ({1'b0, m} + ((WMW+1)'(1) << (d - HW'(1)))) >> d;
    end else begin
      d = top1 - h;
      t = {1'b0, m} << d;
    end
    return t[SCW-1:0];
  endfunction

  // Divide by 2^NF, rounding half away from zero.
  function automatic logic signed [NPW-1:0] rnd_nf(input logic signed [NPW-1:0] x);
    logic [NPW-1:0] m;
    m = x[NPW-1] ? NPW'(-x) : NPW'(x);
    m = (m + (NPW'(1) << (NF - 1))) >> NF;
    return x[NPW-1] ? -signed'(m) : signed'(m);
  endfunction

  // Global advance: hold everything while a finished beat is stalled.
  logic           en;
  logic [NST-1:0] vld;

  assign en        = !(vld[NST-1] && tan_stall);
  assign tri_stall = !en;
  assign tan_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], tri_valid};
    end
  end

  // Stage registers
  logic signed [EW-1:0]   s1_e1 [3];
  logic signed [EW-1:0]   s1_e2 [3];
  logic signed [EW-1:0]   s1_d1u, s1_d1v, s1_d2u, s1_d2v;
  logic signed [CB-1:0]   npipe [1:9][3];
  logic signed [PW-1:0]   s2_pd1, s2_pd2;
  logic signed [PW-1:0]   s2_pa [3];
  logic signed [PW-1:0]   s2_pb [3];
  logic signed [URW-1:0]  s3_ur [3];
  logic                   s3_neg, s3_dz;
  logic [1:0]             stp [4:12];
  logic [UMW-1:0]         s4_mag [3];
  logic [2:0]             s4_sgn;
  logic [UMW-1:0]         s4_or;
  logic [UMW-1:0]         s5_mag [3];
  logic [2:0]             s5_sgn;
  logic [HW-1:0]          s5_h;
  logic signed [USW-1:0]  usp [6:11][3];
  logic signed [DPW-1:0]  s7_dp [3];
  logic signed [DOTW-1:0] s8_dot;
  logic signed [PPW-1:0]  s9_p;
  logic signed [NPW-1:0]  s10_np [3];
  logic signed [RW-1:0]   s11_r [3];
  logic signed [WW-1:0]   s12_w [3];
  logic [WMW-1:0]         s13_mag [3];
  logic [2:0]             s13_sgn;
  logic [WMW-1:0]         s13_or;
  logic [1:0]             s13_st;
  logic [WMW-1:0]         s14_mag [3];
  logic [2:0]             s14_sgn;
  logic [HW-1:0]          s14_h;
  logic [1:0]             s14_st;
  logic [SCW-1:0]         s15_sc [3];
  logic [2:0]             s15_sgn;
  logic [1:0]             s15_st;
  logic [SQW-1:0]         s16_sq [3];
  logic [SCW-1:0]         s16_sc [3];
  logic [2:0]             s16_sgn;
  logic [1:0]             s16_st;

  // Square root pipe: one result bit per stage
  logic [SUMW-1:0]        rt_x    [0:SQ_STEPS];
  logic [REMW-1:0]        rt_rem  [0:SQ_STEPS];
  logic [LW-1:0]          rt_root [0:SQ_STEPS];
  logic [SCW-1:0]         rt_mag  [0:SQ_STEPS][3];
  logic [2:0]             rt_sgn  [0:SQ_STEPS];
  logic [1:0]             rt_st   [0:SQ_STEPS];

  // Division pipe: one quotient bit per stage in each lane
  logic [NUMW-1:0]        dv_r   [0:QW][3];
  logic [QW-1:0]          dv_q   [0:QW][3];
  logic [LW-1:0]          dv_l   [0:QW];
  logic [2:0]             dv_sgn [0:QW];
  logic [1:0]             dv_st  [0:QW];

  // Combinational helpers
  logic signed [URW-1:0]  c3_det;
  logic [UMW-1:0]         c4_mag [3];
  logic [WMW-1:0]         c13_mag [3];
  logic [REMW-1:0]        c_rr    [SQ_STEPS];
  logic [REMW-1:0]        c_trial [SQ_STEPS];
  logic [NUMW:0]          c_dd    [QW];
  logic [CB-1:0]          c_out   [3];

  always_comb begin
    c3_det = URW'(s2_pd1) - URW'(s2_pd2);
    for (int i = 0; i < 3; i++) begin
      c4_mag[i]  = s3_ur[i][URW-1] ? UMW'(-s3_ur[i]) : UMW'(s3_ur[i]);
      c13_mag[i] = s12_w[i][WW-1] ? WMW'(-s12_w[i]) : WMW'(s12_w[i]);
    end
    for (int k = 0; k < SQ_STEPS; k++) begin
      c_rr[k]    = {rt_rem[k][REMW-3:0], rt_x[k][SUMW-1 -: 2]};
      c_trial[k] = REMW'({rt_root[k], 2'b01});
    end
    for (int j = 0; j < QW; j++) begin
      c_dd[j] = (NUMW+1)'(dv_l[j]) << (QW - 1 - j);
    end
    for (int i = 0; i < 3; i++) begin
      c_out[i] = dv_sgn[QW][i] ? CB'(-dv_q[QW][i]) : CB'(dv_q[QW][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Edges and UV deltas
      for (int i = 0; i < 3; i++) begin
        s1_e1[i] <= EW'(comp3(tri_data.pos_b, i)) - EW'(comp3(tri_data.pos_a, i));
        s1_e2[i] <= EW'(comp3(tri_data.pos_c, i)) - EW'(comp3(tri_data.pos_a, i));
        npipe[1][i] <= comp3(tri_data.surface_normal, i);
      end
      s1_d1u <= EW'(comp2(tri_data.tex_b, 0)) - EW'(comp2(tri_data.tex_a, 0));
      s1_d1v <= EW'(comp2(tri_data.tex_b, 1)) - EW'(comp2(tri_data.tex_a, 1));
      s1_d2u <= EW'(comp2(tri_data.tex_c, 0)) - EW'(comp2(tri_data.tex_a, 0));
      s1_d2v <= EW'(comp2(tri_data.tex_c, 1)) - EW'(comp2(tri_data.tex_a, 1));
      for (int k = 2; k <= 9; k++) begin
        npipe[k] <= npipe[k-1];
      end

      // Determinant and tangent products
      s2_pd1 <= s1_d1u * s1_d2v;
      s2_pd2 <= s1_d2u * s1_d1v;
      for (int i = 0; i < 3; i++) begin
        s2_pa[i] <= s1_d2v * s1_e1[i];
        s2_pb[i] <= s1_d1v * s1_e2[i];
      end

      // Raw tangent; only the sign of the determinant matters from here on
      s3_dz  <= (c3_det == '0);
      s3_neg <= c3_det[URW-1];
      for (int i = 0; i < 3; i++) begin
        s3_ur[i] <= URW'(s2_pa[i]) - URW'(s2_pb[i]);
      end

      // Magnitudes; the OR of them has the same top bit as their maximum
      for (int i = 0; i < 3; i++) begin
        s4_mag[i] <= c4_mag[i];
        s4_sgn[i] <= s3_ur[i][URW-1] ^ s3_neg;
      end
      s4_or  <= c4_mag[0] | c4_mag[1] | c4_mag[2];
      stp[4] <= s3_dz ? ST_DET : ST_OK;
      for (int k = 5; k <= 12; k++) begin
        stp[k] <= stp[k-1];
      end

      s5_mag <= s4_mag;
      s5_sgn <= s4_sgn;
      s5_h   <= lead1(WMW'(s4_or));

      // Scale the raw tangent into [2^23, 2^24)
      for (int i = 0; i < 3; i++) begin
        usp[6][i] <= s5_sgn[i]
          ? -USW'(scale_mag(WMW'(s5_mag[i]), s5_h, HW'(UTOP - 1)))
          :  USW'(scale_mag(WMW'(s5_mag[i]), s5_h, HW'(UTOP - 1)));
      end
      for (int k = 7; k <= 11; k++) begin
        usp[k] <= usp[k-1];
      end

      // Projection onto the normal
      for (int i = 0; i < 3; i++) begin
        s7_dp[i] <= npipe[6][i] * usp[6][i];
      end
      s8_dot <= DOTW'(s7_dp[0]) + DOTW'(s7_dp[1]) + DOTW'(s7_dp[2]);
      s9_p   <= PPW'(rnd_nf(NPW'(s8_dot)));
      for (int i = 0; i < 3; i++) begin
        s10_np[i] <= npipe[9][i] * s9_p;
        s11_r[i]  <= RW'(rnd_nf(s10_np[i]));
        s12_w[i]  <= WW'(usp[11][i]) - WW'(s11_r[i]);
      end

      // Drop the normal component; a zero remainder is an error
      for (int i = 0; i < 3; i++) begin
        s13_mag[i] <= c13_mag[i];
        s13_sgn[i] <= s12_w[i][WW-1];
      end
      s13_or <= c13_mag[0] | c13_mag[1] | c13_mag[2];
      s13_st <= (stp[12] == ST_OK && (c13_mag[0] | c13_mag[1] | c13_mag[2]) == '0)
                ? ST_ZERO : stp[12];

      s14_mag <= s13_mag;
      s14_sgn <= s13_sgn;
      s14_st  <= s13_st;
      s14_h   <= lead1(s13_or);

      // Scale into [2^29, 2^30)
      for (int i = 0; i < 3; i++) begin
        s15_sc[i] <= scale_mag(s14_mag[i], s14_h, HW'(WTOP - 1));
      end
      s15_sgn <= s14_sgn;
      s15_st  <= s14_st;

      // Squared length
      for (int i = 0; i < 3; i++) begin
        s16_sq[i] <= s15_sc[i] * s15_sc[i];
      end
      s16_sc  <= s15_sc;
      s16_sgn <= s15_sgn;
      s16_st  <= s15_st;

      rt_x[0]    <= SUMW'(s16_sq[0]) + SUMW'(s16_sq[1]) + SUMW'(s16_sq[2]);
      rt_rem[0]  <= '0;
      rt_root[0] <= '0;
      rt_mag[0]  <= s16_sc;
      rt_sgn[0]  <= s16_sgn;
      rt_st[0]   <= s16_st;

      // Square root, two radicand bits per stage
      for (int k = 0; k < SQ_STEPS; k++) begin
        rt_x[k+1] <= rt_x[k] << 2;
        if (c_rr[k] >= c_trial[k]) begin
          rt_rem[k+1]  <= c_rr[k] - c_trial[k];
          rt_root[k+1] <= {rt_root[k][LW-2:0], 1'b1};
        end else begin
          rt_rem[k+1]  <= c_rr[k];
          rt_root[k+1] <= {rt_root[k][LW-2:0], 1'b0};
        end
        rt_mag[k+1] <= rt_mag[k];
        rt_sgn[k+1] <= rt_sgn[k];
        rt_st[k+1]  <= rt_st[k];
      end

      // Rounded quotient: (|w| * 2^OF + L/2) / L
      for (int i = 0; i < 3; i++) begin
        dv_r[0][i] <= (NUMW'(rt_mag[SQ_STEPS][i]) << OF) + NUMW'(rt_root[SQ_STEPS] >> 1);
        dv_q[0][i] <= '0;
      end
      dv_l[0]   <= rt_root[SQ_STEPS];
      dv_sgn[0] <= rt_sgn[SQ_STEPS];
      dv_st[0]  <= rt_st[SQ_STEPS];

      for (int j = 0; j < QW; j++) begin
        for (int i = 0; i < 3; i++) begin
          if ({1'b0, dv_r[j][i]} >= c_dd[j]) begin
            dv_r[j+1][i] <= dv_r[j][i] - c_dd[j][NUMW-1:0];
            dv_q[j+1][i] <= {dv_q[j][i][QW-2:0], 1'b1};
          end else begin
            dv_r[j+1][i] <= dv_r[j][i];
            dv_q[j+1][i] <= {dv_q[j][i][QW-2:0], 1'b0};
          end
        end
        dv_l[j+1]   <= dv_l[j];
        dv_sgn[j+1] <= dv_sgn[j];
        dv_st[j+1]  <= dv_st[j];
      end

      // Output register; force zero on either error
      tan_data.status <= dv_st[QW];
      if (dv_st[QW] == ST_OK) begin
        tan_data.unit_tangent <= {c_out[2], c_out[1], c_out[0]};
      end else begin
        tan_data.unit_tangent <= '0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    tan_valid && tan_data.status != ST_OK |-> tan_data.unit_tangent == '0)
    else $error("error beat carries a nonzero tangent");

  a_ok_nonzero: assert property (@(posedge clk) disable iff (rst)
    tan_valid && tan_data.status == ST_OK |-> tan_data.unit_tangent != '0)
    else $error("normalized tangent is zero");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    tri_stall |-> tan_valid && tan_stall)
    else $error("input stalled without a held result");
`endif

endmodule
